FILE: rtl/sglpg_pkg.sv
// shared types, constants and the 5x7 font rom of the glyph line pixel generator
// no dependencies; the other rtl files of the block refer to it by scoped names, the testbench imports it
`timescale 1ns / 1ps

package sglpg_pkg;

    // glyph geometry
    localparam int GLYPH_SCALE = 2;
    localparam int TEXT_ROWS   = 16;
    localparam int FONT_ROWS   = 7;
    localparam int FONT_COLS   = 5;
    localparam int LINE_PIXELS = FONT_COLS * GLYPH_SCALE;
    localparam int PX_W        = (LINE_PIXELS > 1) ? $clog2(LINE_PIXELS) : 1;
    localparam int REP_W       = (GLYPH_SCALE > 1) ? $clog2(GLYPH_SCALE) : 1;

    // queue between front and back
    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);

    // stream widths
    localparam int IN_TDATA_W  = 24;
    localparam int OUT_TDATA_W = 24;

    localparam logic [7:0] CHAR_SPACE = 8'h20;

    // tone codes; codes without a member show the actionable color
    typedef enum logic [2:0] {
        TONE_TITLE      = 3'd0,
        TONE_STATIC     = 3'd1,
        TONE_ACTIONABLE = 3'd2,
        TONE_EMPHASIZED = 3'd3,
        TONE_CURRENT    = 3'd4
    } t_tone;

    // configuration register indexes
    typedef enum logic [2:0] {
        CFG_COLOR_TITLE      = 3'd0,
        CFG_COLOR_STATIC     = 3'd1,
        CFG_COLOR_ACTIONABLE = 3'd2,
        CFG_COLOR_EMPHASIZED = 3'd3,
        CFG_COLOR_CURRENT    = 3'd4,
        CFG_COLOR_BACK_BODY  = 3'd5,
        CFG_COLOR_BACK_HINT  = 3'd6,
        CFG_HINT_START_ROW   = 3'd7
    } t_cfg_idx;

    // one configuration write
    typedef struct packed {
        logic        wr_en;
        t_cfg_idx    addr;
        logic [15:0] wdata;
    } t_cfg_wr;

    // one classified glyph line waiting for the serializer
    typedef struct packed {
        logic [15:0] fg;
        logic [15:0] bg;
        logic [4:0]  bits;
    } t_entry;

    // font row from scaled scanline; rows past the glyph come out as seven
    function automatic logic [2:0] font_row(input logic [3:0] line);
        logic [2:0] row;
        row = 3'd0;
        for (int k = 1; k <= FONT_ROWS; k++) begin
            if ({1'b0, line} >= 5'(k * GLYPH_SCALE)) begin
                row = 3'(k);
            end
        end
        return row;
    endfunction

    // whole glyph, top row in the highest five bits; unknown codes are blank
    function automatic logic [34:0] glyph(input logic [7:0] ch);
        logic [34:0] g;
        case (ch)
            8'h41: g = {5'h0e, 5'h11, 5'h11, 5'h1f, 5'h11, 5'h11, 5'h11};
            8'h42: g = {5'h1e, 5'h11, 5'h11, 5'h1e, 5'h11, 5'h11, 5'h1e};
            8'h43: g = {5'h0f, 5'h10, 5'h10, 5'h10, 5'h10, 5'h10, 5'h0f};
            8'h44: g = {5'h1e, 5'h11, 5'h11, 5'h11, 5'h11, 5'h11, 5'h1e};
            8'h45: g = {5'h1f, 5'h10, 5'h10, 5'h1e, 5'h10, 5'h10, 5'h1f};
            8'h46: g = {5'h1f, 5'h10, 5'h10, 5'h1e, 5'h10, 5'h10, 5'h10};
            8'h47: g = {5'h0f, 5'h10, 5'h10, 5'h17, 5'h11, 5'h11, 5'h0f};
            8'h48: g = {5'h11, 5'h11, 5'h11, 5'h1f, 5'h11, 5'h11, 5'h11};
            8'h49: g = {5'h1f, 5'h04, 5'h04, 5'h04, 5'h04, 5'h04, 5'h1f};
            8'h4a: g = {5'h07, 5'h02, 5'h02, 5'h02, 5'h12, 5'h12, 5'h0c};
            8'h4b: g = {5'h11, 5'h12, 5'h14, 5'h18, 5'h14, 5'h12, 5'h11};
            8'h4c: g = {5'h10, 5'h10, 5'h10, 5'h10, 5'h10, 5'h10, 5'h1f};
            8'h4d: g = {5'h11, 5'h1b, 5'h15, 5'h15, 5'h11, 5'h11, 5'h11};
            8'h4e: g = {5'h11, 5'h19, 5'h15, 5'h13, 5'h11, 5'h11, 5'h11};
            8'h4f: g = {5'h0e, 5'h11, 5'h11, 5'h11, 5'h11, 5'h11, 5'h0e};
            8'h50: g = {5'h1e, 5'h11, 5'h11, 5'h1e, 5'h10, 5'h10, 5'h10};
            8'h51: g = {5'h0e, 5'h11, 5'h11, 5'h11, 5'h15, 5'h12, 5'h0d};
            8'h52: g = {5'h1e, 5'h11, 5'h11, 5'h1e, 5'h14, 5'h12, 5'h11};
            8'h53: g = {5'h0f, 5'h10, 5'h10, 5'h0e, 5'h01, 5'h01, 5'h1e};
            8'h54: g = {5'h1f, 5'h04, 5'h04, 5'h04, 5'h04, 5'h04, 5'h04};
            8'h55: g = {5'h11, 5'h11, 5'h11, 5'h11, 5'h11, 5'h11, 5'h0e};
            8'h56: g = {5'h11, 5'h11, 5'h11, 5'h11, 5'h11, 5'h0a, 5'h04};
            8'h57: g = {5'h11, 5'h11, 5'h11, 5'h15, 5'h15, 5'h15, 5'h0a};
            8'h58: g = {5'h11, 5'h11, 5'h0a, 5'h04, 5'h0a, 5'h11, 5'h11};
            8'h59: g = {5'h11, 5'h11, 5'h0a, 5'h04, 5'h04, 5'h04, 5'h04};
            8'h5a: g = {5'h1f, 5'h01, 5'h02, 5'h04, 5'h08, 5'h10, 5'h1f};
            8'h30: g = {5'h0e, 5'h11, 5'h13, 5'h15, 5'h19, 5'h11, 5'h0e};
            8'h31: g = {5'h04, 5'h0c, 5'h04, 5'h04, 5'h04, 5'h04, 5'h0e};
            8'h32: g = {5'h0e, 5'h11, 5'h01, 5'h02, 5'h04, 5'h08, 5'h1f};
            8'h33: g = {5'h1e, 5'h01, 5'h01, 5'h0e, 5'h01, 5'h01, 5'h1e};
            8'h34: g = {5'h02, 5'h06, 5'h0a, 5'h12, 5'h1f, 5'h02, 5'h02};
            8'h35: g = {5'h1f, 5'h10, 5'h10, 5'h1e, 5'h01, 5'h01, 5'h1e};
            8'h36: g = {5'h0e, 5'h10, 5'h10, 5'h1e, 5'h11, 5'h11, 5'h0e};
            8'h37: g = {5'h1f, 5'h01, 5'h02, 5'h04, 5'h08, 5'h08, 5'h08};
            8'h38: g = {5'h0e, 5'h11, 5'h11, 5'h0e, 5'h11, 5'h11, 5'h0e};
            8'h39: g = {5'h0e, 5'h11, 5'h11, 5'h0f, 5'h01, 5'h01, 5'h0e};
            8'h2d: g = {5'h00, 5'h00, 5'h00, 5'h1f, 5'h00, 5'h00, 5'h00};
            8'h3a: g = {5'h00, 5'h00, 5'h04, 5'h00, 5'h00, 5'h04, 5'h00};
            8'h2e: g = {5'h00, 5'h00, 5'h00, 5'h00, 5'h00, 5'h00, 5'h04};
            8'h3d: g = {5'h00, 5'h00, 5'h1f, 5'h00, 5'h1f, 5'h00, 5'h00};
            8'h2f: g = {5'h10, 5'h08, 5'h04, 5'h02, 5'h01, 5'h00, 5'h00};
            8'h5c: g = {5'h01, 5'h02, 5'h04, 5'h08, 5'h10, 5'h00, 5'h00};
            8'h3e: g = {5'h10, 5'h08, 5'h04, 5'h02, 5'h04, 5'h08, 5'h10};
            8'h3c: g = {5'h01, 5'h02, 5'h04, 5'h08, 5'h04, 5'h02, 5'h01};
            8'h3f: g = {5'h0e, 5'h11, 5'h01, 5'h02, 5'h04, 5'h00, 5'h04};
            8'h21: g = {5'h04, 5'h04, 5'h04, 5'h04, 5'h04, 5'h00, 5'h04};
            default: g = '0;
        endcase
        return g;
    endfunction

    // five font bits of one row, leftmost column in bit four
    function automatic logic [4:0] font_bits(input logic [7:0] ch, input logic [2:0] row);
        logic [34:0] g;
        logic [4:0]  b;
        g = glyph(ch);
        b = 5'd0;
        for (int r = 0; r < FONT_ROWS; r++) begin
            if (row == 3'(r)) begin
                b = g[(FONT_ROWS - 1 - r) * FONT_COLS +: FONT_COLS];
            end
        end
        return b;
    endfunction

endpackage

FILE: rtl/sglpg_front.sv
// front part: configuration registers, input beat acceptance, font lookup and color choice
// depends on sglpg_pkg; feeds classified lines to sglpg_queue
`timescale 1ns / 1ps

module sglpg_front (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  sglpg_pkg::t_cfg_wr                i_cfg,
    input  logic                              i_s_axis_tvalid,
    output logic                              o_s_axis_tready,
    input  logic [sglpg_pkg::IN_TDATA_W-1:0]  i_s_axis_tdata,
    input  logic                              i_queue_full,
    output logic                              o_push,
    output sglpg_pkg::t_entry                 o_entry
);

    logic [15:0] r_color_title;
    logic [15:0] r_color_static;
    logic [15:0] r_color_actionable;
    logic [15:0] r_color_emphasized;
    logic [15:0] r_color_current;
    logic [15:0] r_color_back_body;
    logic [15:0] r_color_back_hint;
    logic [4:0]  r_hint_start_row;

    logic [7:0]  char_code;
    logic [2:0]  tone_code;
    logic [3:0]  text_row;
    logic [3:0]  glyph_line;
    logic        hint_row;

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_color_title      <= 16'hF81F;
            r_color_static     <= 16'hFFFC;
            r_color_actionable <= 16'hC618;
            r_color_emphasized <= 16'hFFFF;
            r_color_current    <= 16'h07FF;
            r_color_back_body  <= 16'h0000;
            r_color_back_hint  <= 16'h8010;
            r_hint_start_row   <= 5'd16;
        end else if (i_cfg.wr_en) begin
            case (i_cfg.addr)
                sglpg_pkg::CFG_COLOR_TITLE:      r_color_title      <= i_cfg.wdata;
                sglpg_pkg::CFG_COLOR_STATIC:     r_color_static     <= i_cfg.wdata;
                sglpg_pkg::CFG_COLOR_ACTIONABLE: r_color_actionable <= i_cfg.wdata;
                sglpg_pkg::CFG_COLOR_EMPHASIZED: r_color_emphasized <= i_cfg.wdata;
                sglpg_pkg::CFG_COLOR_CURRENT:    r_color_current    <= i_cfg.wdata;
                sglpg_pkg::CFG_COLOR_BACK_BODY:  r_color_back_body  <= i_cfg.wdata;
                sglpg_pkg::CFG_COLOR_BACK_HINT:  r_color_back_hint  <= i_cfg.wdata;
                sglpg_pkg::CFG_HINT_START_ROW:   r_hint_start_row   <= i_cfg.wdata[4:0];
                default: ;
            endcase
        end
    end

    // unpack the input beat
    assign char_code  = i_s_axis_tdata[7:0];
    assign tone_code  = i_s_axis_tdata[10:8];
    assign text_row   = i_s_axis_tdata[14:11];
    assign glyph_line = i_s_axis_tdata[18:15];

    // accept whenever the queue has room; a space leaves nothing behind
    assign o_s_axis_tready = !i_queue_full;
    assign o_push = i_s_axis_tvalid && !i_queue_full && (char_code != sglpg_pkg::CHAR_SPACE);

    // hint start is saturated at the row count
    assign hint_row = ({1'b0, text_row} >= r_hint_start_row) ||
                      (int'(text_row) >= sglpg_pkg::TEXT_ROWS);

    // foreground by tone, background by row
    always_comb begin
        case (sglpg_pkg::t_tone'(tone_code))
            sglpg_pkg::TONE_TITLE:      o_entry.fg = r_color_title;
            sglpg_pkg::TONE_STATIC:     o_entry.fg = r_color_static;
            sglpg_pkg::TONE_EMPHASIZED: o_entry.fg = r_color_emphasized;
            sglpg_pkg::TONE_CURRENT:    o_entry.fg = r_color_current;
            default:                    o_entry.fg = r_color_actionable;
        endcase
        o_entry.bg   = hint_row ? r_color_back_hint : r_color_back_body;
        o_entry.bits = sglpg_pkg::font_bits(char_code, sglpg_pkg::font_row(glyph_line));
    end

endmodule

FILE: rtl/sglpg_queue.sv
// short first-in first-out queue of classified glyph lines between front and back
// depends on sglpg_pkg for the entry type and depth
`timescale 1ns / 1ps

module sglpg_queue (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_push,
    input  sglpg_pkg::t_entry i_entry,
    output logic              o_full,
    input  logic              i_pop,
    output sglpg_pkg::t_entry o_entry,
    output logic              o_empty
);

    sglpg_pkg::t_entry                r_mem [sglpg_pkg::QUEUE_DEPTH];
    logic [sglpg_pkg::QPTR_W-1:0]     r_wr_ptr;
    logic [sglpg_pkg::QPTR_W-1:0]     r_rd_ptr;
    logic [sglpg_pkg::QPTR_W:0]       r_count;
    logic                             do_push;
    logic                             do_pop;

    assign o_full  = (r_count == (sglpg_pkg::QPTR_W + 1)'(sglpg_pkg::QUEUE_DEPTH));
    assign o_empty = (r_count == '0);
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && !o_empty;
    assign o_entry = r_mem[r_rd_ptr];

    // pointers and fill level
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (do_push) begin
                r_wr_ptr <= r_wr_ptr + 1'b1;
            end
            if (do_pop) begin
                r_rd_ptr <= r_rd_ptr + 1'b1;
            end
            case ({do_push, do_pop})
                2'b10:   r_count <= r_count + 1'b1;
                2'b01:   r_count <= r_count - 1'b1;
                default: r_count <= r_count;
            endcase
        end
    end

    // storage
    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr_ptr] <= i_entry;
        end
    end

endmodule

FILE: rtl/sglpg_back.sv
// back part: serializes one glyph line into pixel beats through an output register
// depends on sglpg_pkg; takes entries from sglpg_queue
`timescale 1ns / 1ps

module sglpg_back (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  sglpg_pkg::t_entry                 i_entry,
    input  logic                              i_empty,
    output logic                              o_pop,
    output logic                              o_m_axis_tvalid,
    input  logic                              i_m_axis_tready,
    output logic [sglpg_pkg::OUT_TDATA_W-1:0] o_m_axis_tdata,
    output logic                              o_m_axis_tlast
);

    logic                            r_busy;
    logic [15:0]                     r_fg;
    logic [15:0]                     r_bg;
    logic [4:0]                      r_bits;
    logic [sglpg_pkg::PX_W-1:0]      r_px;
    logic [sglpg_pkg::REP_W-1:0]     r_rep;

    logic                            r_out_valid;
    logic [15:0]                     r_out_color;
    logic [3:0]                      r_out_index;
    logic                            r_out_last;

    logic                            advance;
    logic                            line_end;
    logic                            load;

    // output register moves when empty or taken
    assign advance  = !r_out_valid || i_m_axis_tready;
    assign line_end = r_busy && (r_px == sglpg_pkg::PX_W'(sglpg_pkg::LINE_PIXELS - 1));
    // next line is picked up as the last pixel leaves, so lines run without gaps
    assign load     = !i_empty && (!r_busy || (advance && line_end));
    assign o_pop    = load;

    // pixel counters and current line
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
        end else begin
            if (advance && r_busy) begin
                if (line_end) begin
                    r_busy <= 1'b0;
                end else begin
                    r_px <= r_px + 1'b1;
                    if (r_rep == sglpg_pkg::REP_W'(sglpg_pkg::GLYPH_SCALE - 1)) begin
                        r_rep  <= '0;
                        r_bits <= {r_bits[3:0], 1'b0};
                    end else begin
                        r_rep <= r_rep + 1'b1;
                    end
                end
            end
            if (load) begin
                r_busy <= 1'b1;
                r_fg   <= i_entry.fg;
                r_bg   <= i_entry.bg;
                r_bits <= i_entry.bits;
                r_px   <= '0;
                r_rep  <= '0;
            end
        end
    end

    // output beat register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance) begin
            r_out_valid <= r_busy;
            if (r_busy) begin
                r_out_color <= r_bits[4] ? r_fg : r_bg;
                r_out_index <= 4'(r_px);
                r_out_last  <= line_end;
            end
        end
    end

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = {4'd0, r_out_index, r_out_color};
    assign o_m_axis_tlast  = r_out_last;

endmodule

FILE: rtl/scaled_glyph_line_pixel_generator_core.sv
// top level of the scaled glyph line pixel generator: front, queue and back
// depends on sglpg_pkg, sglpg_front, sglpg_queue and sglpg_back
`timescale 1ns / 1ps

// Each input beat names a character, its tone, its text row and one scanline of the
// glyph scaled by GLYPH_SCALE; the block emits 5*GLYPH_SCALE RGB565 pixel beats, left
// first, with tlast on the final one, and a space emits nothing. The back part puts out
// one pixel per cycle while the receiver takes them; consecutive lines follow without a
// gap. The front takes a new beat every cycle while the four-entry queue has room, so
// input beats keep flowing while pixels of earlier lines are still waiting downstream,
// and a space is accepted but takes no queue entry. An accepted beat passes the queue,
// the line registers and the output register of the back part before its first pixel
// leaves. Colors and the hint start row are to be written on the configuration port while
// the block is idle, which it does not enforce; there is no clearing pass after reset.

module scaled_glyph_line_pixel_generator_core (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // configuration write port
    input  logic        i_cfg_wr_en,
    input  logic [2:0]  i_cfg_addr,
    input  logic [15:0] i_cfg_wdata,
    // input stream
    input  logic        i_s_axis_tvalid,
    output logic        o_s_axis_tready,
    // char_code[7:0], tone_code[10:8], text_row[14:11], glyph_line[18:15], zero[23:19]
    input  logic [23:0] i_s_axis_tdata,
    // pixel stream
    output logic        o_m_axis_tvalid,
    input  logic        i_m_axis_tready,
    // pixel_color[15:0], pixel_index[19:16], zero[23:20]
    output logic [23:0] o_m_axis_tdata,
    // last_pixel
    output logic        o_m_axis_tlast
);

    sglpg_pkg::t_cfg_wr cfg;
    sglpg_pkg::t_entry  front_entry;
    sglpg_pkg::t_entry  queue_entry;
    logic               push;
    logic               pop;
    logic               queue_full;
    logic               queue_empty;

    assign cfg.wr_en = i_cfg_wr_en;
    assign cfg.addr  = sglpg_pkg::t_cfg_idx'(i_cfg_addr);
    assign cfg.wdata = i_cfg_wdata;

    // accept and classify
    sglpg_front u_front (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg           (cfg),
        .i_s_axis_tvalid (i_s_axis_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (i_s_axis_tdata),
        .i_queue_full    (queue_full),
        .o_push          (push),
        .o_entry         (front_entry)
    );

    // decoupling queue
    sglpg_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_entry (front_entry),
        .o_full  (queue_full),
        .i_pop   (pop),
        .o_entry (queue_entry),
        .o_empty (queue_empty)
    );

    // pixel serializer
    sglpg_back u_back (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_entry         (queue_entry),
        .i_empty         (queue_empty),
        .o_pop           (pop),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (i_m_axis_tready),
        .o_m_axis_tdata  (o_m_axis_tdata),
        .o_m_axis_tlast  (o_m_axis_tlast)
    );

    // tlast marks exactly the final pixel position
    a_last_index : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid |-> (o_m_axis_tlast ==
            (o_m_axis_tdata[19:16] == 4'(sglpg_pkg::LINE_PIXELS - 1))))
        else $error("tlast does not match pixel index");

    // within a line the next pixel beat follows at once with the next index
    a_index_step : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_axis_tvalid && i_m_axis_tready && !o_m_axis_tlast) |=>
            (o_m_axis_tvalid && (o_m_axis_tdata[19:16] == $past(o_m_axis_tdata[19:16]) + 4'd1)))
        else $error("pixel beats of a line are not contiguous");

    // a line starts at pixel zero
    a_line_start : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_axis_tvalid && i_m_axis_tready && o_m_axis_tlast) |=>
            (!o_m_axis_tvalid || (o_m_axis_tdata[19:16] == 4'd0)))
        else $error("new line does not start at pixel zero");

    // the queue is never both full and empty, and no pop from an empty queue
    a_queue_sane : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(queue_full && queue_empty) && !(pop && queue_empty))
        else $error("queue state inconsistent");

endmodule

FILE: tb/scaled_glyph_line_pixel_generator_core_tb.sv
// self-checking testbench of the scaled glyph line pixel generator core
// depends on sglpg_pkg and scaled_glyph_line_pixel_generator_core; needs no files at run time
`timescale 1ns / 1ps

module scaled_glyph_line_pixel_generator_core_tb;

    import sglpg_pkg::*;

    localparam int    CYCLE_LIMIT  = 400000;
    localparam int    SETTLE_TICKS = 12;
    localparam int    PHASE_BEATS  = 33;
    localparam string CHARSET      = "ABCDEFGHIJKLMNOPQRSTUVWXYZ0123456789-:.=/\\><?! ";

    // one character beat, char_code in the lowest bits
    typedef struct packed {
        logic [3:0] glyph_line;
        logic [3:0] text_row;
        logic [2:0] tone;
        logic [7:0] char_code;
    } char_beat_t;

    // one pixel beat as it should leave the block
    typedef struct packed {
        logic [15:0] color;
        logic [3:0]  index;
        logic        last;
    } pixel_t;

    // glyph line renderer with its own register copy and the queue of pixels still due
    class glyph_line_checker;
        logic [15:0] reg_file [8];
        pixel_t      pixels_due [$];
        int          mismatch_count;

        function new();
            mismatch_count = 0;
            reg_file[CFG_COLOR_TITLE]      = 16'hF81F;
            reg_file[CFG_COLOR_STATIC]     = 16'hFFFC;
            reg_file[CFG_COLOR_ACTIONABLE] = 16'hC618;
            reg_file[CFG_COLOR_EMPHASIZED] = 16'hFFFF;
            reg_file[CFG_COLOR_CURRENT]    = 16'h07FF;
            reg_file[CFG_COLOR_BACK_BODY]  = 16'h0000;
            reg_file[CFG_COLOR_BACK_HINT]  = 16'h8010;
            reg_file[CFG_HINT_START_ROW]   = 16'd16;
        endfunction

        // the hint start row keeps only five bits
        function void write_reg(t_cfg_idx idx, logic [15:0] value);
            if (idx == CFG_HINT_START_ROW) begin
                reg_file[idx] = {11'd0, value[4:0]};
            end else begin
                reg_file[idx] = value;
            end
        endfunction

        // five font bits of one glyph row, leftmost column in bit four
        function logic [4:0] glyph_bits(logic [7:0] ch, int unsigned row);
            logic [4:0] r [7];
            if (row >= 7) return 5'h00;
            r = '{default: 5'h00};
            case (ch)
                "A": r = '{5'h0e, 5'h11, 5'h11, 5'h1f, 5'h11, 5'h11, 5'h11};
                "B": r = '{5'h1e, 5'h11, 5'h11, 5'h1e, 5'h11, 5'h11, 5'h1e};
                "C": r = '{5'h0f, 5'h10, 5'h10, 5'h10, 5'h10, 5'h10, 5'h0f};
                "D": r = '{5'h1e, 5'h11, 5'h11, 5'h11, 5'h11, 5'h11, 5'h1e};
                "E": r = '{5'h1f, 5'h10, 5'h10, 5'h1e, 5'h10, 5'h10, 5'h1f};
                "F": r = '{5'h1f, 5'h10, 5'h10, 5'h1e, 5'h10, 5'h10, 5'h10};
                "G": r = '{5'h0f, 5'h10, 5'h10, 5'h17, 5'h11, 5'h11, 5'h0f};
                "H": r = '{5'h11, 5'h11, 5'h11, 5'h1f, 5'h11, 5'h11, 5'h11};
                "I": r = '{5'h1f, 5'h04, 5'h04, 5'h04, 5'h04, 5'h04, 5'h1f};
                "J": r = '{5'h07, 5'h02, 5'h02, 5'h02, 5'h12, 5'h12, 5'h0c};
                "K": r = '{5'h11, 5'h12, 5'h14, 5'h18, 5'h14, 5'h12, 5'h11};
                "L": r = '{5'h10, 5'h10, 5'h10, 5'h10, 5'h10, 5'h10, 5'h1f};
                "M": r = '{5'h11, 5'h1b, 5'h15, 5'h15, 5'h11, 5'h11, 5'h11};
                "N": r = '{5'h11, 5'h19, 5'h15, 5'h13, 5'h11, 5'h11, 5'h11};
                "O": r = '{5'h0e, 5'h11, 5'h11, 5'h11, 5'h11, 5'h11, 5'h0e};
                "P": r = '{5'h1e, 5'h11, 5'h11, 5'h1e, 5'h10, 5'h10, 5'h10};
                "Q": r = '{5'h0e, 5'h11, 5'h11, 5'h11, 5'h15, 5'h12, 5'h0d};
                "R": r = '{5'h1e, 5'h11, 5'h11, 5'h1e, 5'h14, 5'h12, 5'h11};
                "S": r = '{5'h0f, 5'h10, 5'h10, 5'h0e, 5'h01, 5'h01, 5'h1e};
                "T": r = '{5'h1f, 5'h04, 5'h04, 5'h04, 5'h04, 5'h04, 5'h04};
                "U": r = '{5'h11, 5'h11, 5'h11, 5'h11, 5'h11, 5'h11, 5'h0e};
                "V": r = '{5'h11, 5'h11, 5'h11, 5'h11, 5'h11, 5'h0a, 5'h04};
                "W": r = '{5'h11, 5'h11, 5'h11, 5'h15, 5'h15, 5'h15, 5'h0a};
                "X": r = '{5'h11, 5'h11, 5'h0a, 5'h04, 5'h0a, 5'h11, 5'h11};
                "Y": r = '{5'h11, 5'h11, 5'h0a, 5'h04, 5'h04, 5'h04, 5'h04};
                "Z": r = '{5'h1f, 5'h01, 5'h02, 5'h04, 5'h08, 5'h10, 5'h1f};
                "0": r = '{5'h0e, 5'h11, 5'h13, 5'h15, 5'h19, 5'h11, 5'h0e};
                "1": r = '{5'h04, 5'h0c, 5'h04, 5'h04, 5'h04, 5'h04, 5'h0e};
                "2": r = '{5'h0e, 5'h11, 5'h01, 5'h02, 5'h04, 5'h08, 5'h1f};
                "3": r = '{5'h1e, 5'h01, 5'h01, 5'h0e, 5'h01, 5'h01, 5'h1e};
                "4": r = '{5'h02, 5'h06, 5'h0a, 5'h12, 5'h1f, 5'h02, 5'h02};
                "5": r = '{5'h1f, 5'h10, 5'h10, 5'h1e, 5'h01, 5'h01, 5'h1e};
                "6": r = '{5'h0e, 5'h10, 5'h10, 5'h1e, 5'h11, 5'h11, 5'h0e};
                "7": r = '{5'h1f, 5'h01, 5'h02, 5'h04, 5'h08, 5'h08, 5'h08};
                "8": r = '{5'h0e, 5'h11, 5'h11, 5'h0e, 5'h11, 5'h11, 5'h0e};
                "9": r = '{5'h0e, 5'h11, 5'h11, 5'h0f, 5'h01, 5'h01, 5'h0e};
                "-": r[3] = 5'h1f;
                ":": begin
                    r[2] = 5'h04;
                    r[5] = 5'h04;
                end
                ".": r[6] = 5'h04;
                "=": begin
                    r[2] = 5'h1f;
                    r[4] = 5'h1f;
                end
                "/": for (int k = 0; k < 5; k++) r[k] = 5'(1 << (4 - k));
                "\\": for (int k = 0; k < 5; k++) r[k] = 5'(1 << k);
                ">": r = '{5'h10, 5'h08, 5'h04, 5'h02, 5'h04, 5'h08, 5'h10};
                "<": r = '{5'h01, 5'h02, 5'h04, 5'h08, 5'h04, 5'h02, 5'h01};
                "?": r = '{5'h0e, 5'h11, 5'h01, 5'h02, 5'h04, 5'h00, 5'h04};
                "!": r = '{5'h04, 5'h04, 5'h04, 5'h04, 5'h04, 5'h00, 5'h04};
                default: ;
            endcase
            return r[row];
        endfunction

        // queue the pixels of one accepted character beat; a space draws nothing
        function void render_beat(char_beat_t cb);
            logic [15:0] fg;
            logic [15:0] bg;
            logic [4:0]  bits;
            int unsigned hs;
            pixel_t      p;
            if (cb.char_code == CHAR_SPACE) return;
            hs = reg_file[CFG_HINT_START_ROW][4:0];
            if (hs > TEXT_ROWS) hs = TEXT_ROWS;
            case (t_tone'(cb.tone))
                TONE_TITLE:      fg = reg_file[CFG_COLOR_TITLE];
                TONE_STATIC:     fg = reg_file[CFG_COLOR_STATIC];
                TONE_EMPHASIZED: fg = reg_file[CFG_COLOR_EMPHASIZED];
                TONE_CURRENT:    fg = reg_file[CFG_COLOR_CURRENT];
                default:         fg = reg_file[CFG_COLOR_ACTIONABLE];
            endcase
            bg = (cb.text_row >= hs) ? reg_file[CFG_COLOR_BACK_HINT]
                                     : reg_file[CFG_COLOR_BACK_BODY];
            bits = glyph_bits(cb.char_code, cb.glyph_line / GLYPH_SCALE);
            for (int px = 0; px < LINE_PIXELS; px++) begin
                p.color = bits[4 - px / GLYPH_SCALE] ? fg : bg;
                p.index = 4'(px);
                p.last  = (px == LINE_PIXELS - 1);
                pixels_due.push_back(p);
            end
        endfunction

        task flag_mismatch(string msg);
            $display("mismatch: %s", msg);
            mismatch_count++;
        endtask

        // compare one accepted pixel beat with the oldest pixel due
        task check_pixel(pixel_t got);
            pixel_t want;
            if (pixels_due.size() == 0) begin
                flag_mismatch($sformatf("unexpected pixel color %h index %0d",
                                        got.color, got.index));
                return;
            end
            want = pixels_due.pop_front();
            if (got.color !== want.color)
                flag_mismatch($sformatf("index %0d color %h, want %h",
                                        want.index, got.color, want.color));
            if (got.index !== want.index)
                flag_mismatch($sformatf("pixel index %0d, want %0d", got.index, want.index));
            if (got.last !== want.last)
                flag_mismatch($sformatf("index %0d last %b, want %b",
                                        want.index, got.last, want.last));
        endtask
    endclass

    logic        clk;
    logic        rst_n;
    logic        cfg_wr_en;
    logic [2:0]  cfg_addr;
    logic [15:0] cfg_wdata;
    logic        char_valid;
    logic        char_ready;
    logic [23:0] char_data;
    logic        pix_valid;
    logic        pix_ready;
    logic [23:0] pix_data;
    logic        pix_last;

    glyph_line_checker lines;
    int          cycle_count;
    int          burst_left;
    bit          tx_gappy;
    int          rx_mode;
    int unsigned rx_tick;
    int          beats_sent;

    scaled_glyph_line_pixel_generator_core i_dut (
        .i_clk           (clk),
        .i_rst_n         (rst_n),
        .i_cfg_wr_en     (cfg_wr_en),
        .i_cfg_addr      (cfg_addr),
        .i_cfg_wdata     (cfg_wdata),
        .i_s_axis_tvalid (char_valid),
        .o_s_axis_tready (char_ready),
        .i_s_axis_tdata  (char_data),
        .o_m_axis_tvalid (pix_valid),
        .i_m_axis_tready (pix_ready),
        .o_m_axis_tdata  (pix_data),
        .o_m_axis_tlast  (pix_last)
    );

    // 2 ns clock
    initial begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    // watchdog
    always @(posedge clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("FAILED: results differ");
            $finish;
        end
    end

    // receiver stall patterns, changed per phase
    always @(negedge clk) begin
        rx_tick++;
        case (rx_mode)
            0:       pix_ready = 1'b1;
            1:       pix_ready = ($urandom_range(0, 3) != 0);
            2:       pix_ready = ((rx_tick % 9) >= 3);
            default: pix_ready = ($urandom_range(0, 5) == 0);
        endcase
    end

    // pixel monitor
    always @(posedge clk) begin
        if (rst_n && pix_valid && pix_ready)
            lines.check_pixel('{color: pix_data[15:0], index: pix_data[19:16], last: pix_last});
    end

    function automatic char_beat_t make_beat(logic [7:0] ch, logic [2:0] tone,
                                             logic [3:0] row, logic [3:0] line);
        char_beat_t cb;
        cb.char_code  = ch;
        cb.tone       = tone;
        cb.text_row   = row;
        cb.glyph_line = line;
        return cb;
    endfunction

    // mostly characters the font knows, some of any code
    function automatic logic [7:0] random_char();
        if ($urandom_range(0, 3) != 0) return CHARSET[$urandom_range(0, CHARSET.len() - 1)];
        return 8'($urandom_range(0, 255));
    endfunction

    // mostly scanlines inside the glyph, sometimes past it
    function automatic logic [3:0] random_line();
        if ($urandom_range(0, 7) == 0) return 4'($urandom_range(14, 15));
        return 4'($urandom_range(0, 13));
    endfunction

    // drive one character beat, with a random gap before each burst when gappy sending is on
    task send_beat(char_beat_t cb);
        int gap;
        @(negedge clk);
        if (burst_left == 0) begin
            if (tx_gappy) begin
                gap = ($urandom_range(0, 5) == 0) ? $urandom_range(5, 15) : $urandom_range(1, 4);
                char_valid = 1'b0;
                repeat (gap) @(negedge clk);
                burst_left = $urandom_range(1, 12);
            end else begin
                burst_left = 1000000;
            end
        end
        char_valid = 1'b1;
        char_data  = {5'd0, cb};
        do @(posedge clk); while (!char_ready);
        lines.render_beat(cb);
        burst_left--;
        beats_sent++;
    endtask

    // a run of characters on one scanline of one text row, as a display would ask
    task send_text_run();
        int         n;
        logic [2:0] tone;
        logic [3:0] row;
        logic [3:0] line;
        n    = $urandom_range(1, 6);
        tone = 3'($urandom_range(0, 7));
        row  = 4'($urandom_range(0, 15));
        line = random_line();
        for (int k = 0; k < n; k++) send_beat(make_beat(random_char(), tone, row, line));
    endtask

    task write_reg(t_cfg_idx idx, logic [15:0] value);
        @(negedge clk);
        cfg_wr_en = 1'b1;
        cfg_addr  = idx;
        cfg_wdata = value;
        @(posedge clk);
        lines.write_reg(idx, value);
        @(negedge clk);
        cfg_wr_en = 1'b0;
    endtask

    // stop sending and wait for every pending pixel to leave
    task settle();
        @(negedge clk);
        char_valid = 1'b0;
        while (lines.pixels_due.size() != 0) @(posedge clk);
        repeat (SETTLE_TICKS) @(posedge clk);
    endtask

    initial begin
        logic [15:0] fg_val;
        logic [15:0] bg_val;
        logic [4:0]  hint;
        int          start;
        cycle_count = 0;
        rx_tick     = 0;
        rst_n       = 1'b0;
        cfg_wr_en   = 1'b0;
        cfg_addr    = '0;
        cfg_wdata   = '0;
        char_valid  = 1'b0;
        char_data   = '0;
        pix_ready   = 1'b0;
        rx_mode     = 1;
        tx_gappy    = 1'b1;
        burst_left  = 0;
        beats_sent  = 0;
        lines       = new();
        repeat (2) @(negedge clk);
        rst_n = 1'b1;

        // directed: reset colors, every tone, the marks, blanks and scanlines past the glyph
        send_beat(make_beat("A", 3'd0, 4'd0, 4'd0));
        send_beat(make_beat("B", 3'd1, 4'd1, 4'd1));
        send_beat(make_beat("M", 3'd2, 4'd2, 4'd5));
        send_beat(make_beat("W", 3'd3, 4'd3, 4'd12));
        send_beat(make_beat("8", 3'd4, 4'd15, 4'd13));
        send_beat(make_beat("0", 3'd5, 4'd7, 4'd6));
        send_beat(make_beat("?", 3'd6, 4'd8, 4'd8));
        send_beat(make_beat("!", 3'd7, 4'd14, 4'd12));
        send_beat(make_beat(CHAR_SPACE, 3'd0, 4'd0, 4'd0));
        send_beat(make_beat(8'h00, 3'd3, 4'd5, 4'd2));
        send_beat(make_beat(8'hFF, 3'd7, 4'd15, 4'd15));
        send_beat(make_beat("a", 3'd1, 4'd9, 4'd4));
        send_beat(make_beat("Z", 3'd2, 4'd4, 4'd14));
        send_beat(make_beat("Q", 3'd4, 4'd6, 4'd15));
        send_beat(make_beat("-", 3'd0, 4'd10, 4'd6));
        send_beat(make_beat(":", 3'd1, 4'd11, 4'd4));
        send_beat(make_beat(".", 3'd2, 4'd12, 4'd12));
        send_beat(make_beat("=", 3'd3, 4'd13, 4'd8));
        send_beat(make_beat("/", 3'd4, 4'd0, 4'd0));
        send_beat(make_beat("\\", 3'd5, 4'd1, 4'd8));
        send_beat(make_beat(">", 3'd6, 4'd2, 4'd6));
        send_beat(make_beat("<", 3'd7, 4'd3, 4'd2));
        send_beat(make_beat("G", 3'd0, 4'd4, 4'd7));

        // random phases, each with its own register setting and idling pattern
        for (int p = 0; p < 6; p++) begin
            settle();
            for (int r = 0; r < 8; r++) begin
                fg_val = 16'($urandom());
                bg_val = 16'($urandom());
                if (p == 0) begin
                    fg_val = 16'hFFFF;
                    bg_val = 16'h0000;
                end else if (p == 1) begin
                    fg_val = 16'h0000;
                    bg_val = 16'hFFFF;
                end
                case (p)
                    0:       hint = 5'd0;
                    1:       hint = 5'd31;
                    2:       hint = 5'd16;
                    3:       hint = 5'd17;
                    4:       hint = 5'd15;
                    default: hint = 5'($urandom_range(1, 14));
                endcase
                case (t_cfg_idx'(r))
                    CFG_COLOR_BACK_BODY,
                    CFG_COLOR_BACK_HINT: write_reg(t_cfg_idx'(r), bg_val);
                    CFG_HINT_START_ROW:  write_reg(t_cfg_idx'(r), {fg_val[15:5], hint});
                    default:             write_reg(t_cfg_idx'(r), fg_val);
                endcase
            end
            rx_mode    = p % 4;
            tx_gappy   = (p != 0);
            burst_left = 0;
            start      = beats_sent;
            while (beats_sent - start < PHASE_BEATS) begin
                if ($urandom_range(0, 9) < 6) begin
                    send_text_run();
                end else begin
                    send_beat(make_beat(random_char(), 3'($urandom_range(0, 7)),
                                        4'($urandom_range(0, 15)), random_line()));
                end
            end
        end

        settle();
        if (lines.pixels_due.size() != 0)
            lines.flag_mismatch("pixels still due at end of run");
        if (lines.mismatch_count == 0) begin
            $display("PASSED: all results match");
        end else begin
            $display("FAILED: results differ");
        end
        $finish;
    end

endmodule

FILE: files.f
rtl/sglpg_pkg.sv
rtl/sglpg_front.sv
rtl/sglpg_queue.sv
rtl/sglpg_back.sv
rtl/scaled_glyph_line_pixel_generator_core.sv
tb/scaled_glyph_line_pixel_generator_core_tb.sv
